[rtl/ttrm_pkg.sv]
// Shared types and constants for the touch-to-relative-motion unit.
// Used by ttrm_ctrl, ttrm_dp and the top level; depends on nothing.
`default_nettype none

package ttrm_pkg;

    localparam int POS_W      = 16;   // absolute coordinate width
    localparam int MOVE_W     = 8;    // HID motion width
    localparam int LIM_W      = 10;   // jump limit / threshold width
    localparam int GAIN_W     = 12;   // gain register width
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [MOVE_W-1:0] HID_MAX = 8'sd127;
    localparam logic [MOVE_W-1:0] HID_MIN = -8'sd127;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_JUMP_LIMIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_THR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_BASE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_SLOPE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_CAP   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [LIM_W-1:0]  RST_JUMP_LIMIT = 10'd64;
    localparam logic [LIM_W-1:0]  RST_ACCEL_THR  = 10'd2;
    localparam logic [GAIN_W-1:0] RST_GAIN_BASE  = 12'd256;
    localparam logic [GAIN_W-1:0] RST_GAIN_SLOPE = 12'd32;
    localparam logic [GAIN_W-1:0] RST_GAIN_CAP   = 12'd768;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture sample, update position state
        logic gain;   // acceleration product
        logic cap;    // base add and cap
        logic mul;    // scale deltas by gain
        logic fin;    // remainder update and output register load
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go;     // sample moves the pointer (touched, enabled, tracking, no jump)
    } t_status;

endpackage

`default_nettype wire

[rtl/touch_to_relative_motion_unit.sv]
// Touch-to-relative-motion unit, top level: ties the controller to the datapath.
// Depends on ttrm_pkg, ttrm_ctrl and ttrm_dp.
//
// Turns absolute touch samples into clamped HID relative motion with speed-based
// gain and a kept sub-pixel remainder; every accepted sample gives exactly one
// result transaction. A sample that moves the pointer passes from acceptance to
// the output register through capture, acceleration multiply, base add and cap,
// scaling multiply and remainder update; a sample that gives zero motion (released,
// disabled, first touch, or a jump) goes from capture straight to the finish step.
// The next sample is accepted in the cycle after the result is loaded, while that
// result still waits on the master side; the finish step waits only if an earlier
// result has not been taken. Configuration writes take effect at once and are
// meant to be issued while no sample is in flight.
`default_nettype none

module touch_to_relative_motion_unit #(
    parameter int FRAC_BITS = ttrm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [31:0]                      s_axis_tdata,  // pos_x, pos_y
    input  wire logic [1:0]                       s_axis_tuser,  // is_touched, is_enabled
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // move_x, move_y
    input  wire logic                             i_cfg_we,
    input  wire logic [ttrm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ttrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ttrm_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [MOVE_W-1:0] move_x, move_y;

    ttrm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    ttrm_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_pos_x      (s_axis_tdata[POS_W-1:0]),
        .i_pos_y      (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_is_touched (s_axis_tuser[0]),
        .i_is_enabled (s_axis_tuser[1]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_move_x     (move_x),
        .o_move_y     (move_y)
    );

    assign m_axis_tdata = {move_y, move_x};

endmodule

`default_nettype wire

[rtl/ttrm_ctrl.sv]
// Sequencing controller for the touch-to-relative-motion unit.
// Depends on ttrm_pkg; drives ttrm_dp through t_cmd and owns the handshakes.
`default_nettype none

module ttrm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire ttrm_pkg::t_status i_status,
    output ttrm_pkg::t_cmd        o_cmd
);
    import ttrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_CAP,
        S_MUL,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept;
    logic   out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_valid || m_axis_tready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        o_cmd.gain = (r_state == S_GAIN);
        o_cmd.cap  = (r_state == S_CAP);
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.fin  = (r_state == S_FIN) && out_free;
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        if (r_valid && m_axis_tready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.go ? S_GAIN : S_FIN;
                end
            end
            S_GAIN: n_state = S_CAP;
            S_CAP:  n_state = S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.gain, o_cmd.cap, o_cmd.mul, o_cmd.fin, o_cmd.load}))
        else $error("more than one datapath command active");

    a_go_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.go) |=> (r_state == S_GAIN))
        else $error("moving sample did not enter gain step");

    a_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_status.go) |=> (r_state == S_FIN))
        else $error("zero-result sample did not go to finish");

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> (r_valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

`default_nettype wire

[rtl/ttrm_dp.sv]
// Datapath of the touch-to-relative-motion unit: config registers, position
// state, gain pipeline and sub-pixel remainders. Depends on ttrm_pkg.
`default_nettype none

module ttrm_dp #(
    parameter int FRAC_BITS = ttrm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ttrm_pkg::t_cmd                      i_cmd,
    output ttrm_pkg::t_status                        o_status,
    input  wire logic [ttrm_pkg::POS_W-1:0]          i_pos_x,
    input  wire logic [ttrm_pkg::POS_W-1:0]          i_pos_y,
    input  wire logic                                i_is_touched,
    input  wire logic                                i_is_enabled,
    input  wire logic                                i_cfg_we,
    input  wire logic [ttrm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [ttrm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [ttrm_pkg::MOVE_W-1:0]              o_move_x,
    output logic [ttrm_pkg::MOVE_W-1:0]              o_move_y
);
    import ttrm_pkg::*;

    localparam int DX_W    = LIM_W + 1;               // signed delta once under the limit
    localparam int OVER_P_W = LIM_W + GAIN_W;         // acceleration product
    localparam int SUM_W   = OVER_P_W + 1;
    localparam int PROD_W  = DX_W + GAIN_W + 1;       // signed scaled delta
    localparam int ACC_W   = (FRAC_BITS + 2 > PROD_W + 1) ? FRAC_BITS + 2 : PROD_W + 1;
    localparam int WHOLE_W = ACC_W - FRAC_BITS;

    typedef struct packed {
        logic [MOVE_W-1:0]         move;
        logic signed [FRAC_BITS:0] frac;
    } t_axis;

    // configuration
    logic [LIM_W-1:0]  r_jump_limit, r_accel_thr;
    logic [GAIN_W-1:0] r_gain_base, r_gain_slope, r_gain_cap;

    // sample state
    logic              r_tracking;
    logic [POS_W-1:0]  r_last_x, r_last_y;
    logic signed [FRAC_BITS:0] r_frac_x, r_frac_y;

    // working registers
    logic              r_zero;
    logic signed [DX_W-1:0]   r_dx, r_dy;
    logic [LIM_W-1:0]  r_ax, r_ay;
    logic [OVER_P_W-1:0] r_over_prod;
    logic [GAIN_W-1:0] r_gain;
    logic signed [PROD_W-1:0] r_scaled_x, r_scaled_y;
    logic [MOVE_W-1:0] r_move_x, r_move_y;

    // combinational logic for the load, gain, cap and finish steps
    logic signed [POS_W:0] dx_full, dy_full;
    logic [POS_W-1:0]      ax_full, ay_full;
    logic                  active, jump;
    logic [LIM_W-1:0]      speed, over;
    logic [SUM_W-1:0]      gain_sum;
    t_axis                 res_x, res_y;

    function automatic t_axis take_whole(logic signed [FRAC_BITS:0] rem,
                                         logic signed [PROD_W-1:0] scaled);
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        mag;
        logic [WHOLE_W-1:0]      whole;
        logic [FRAC_BITS:0]      low;
        t_axis                   res;
        acc   = ACC_W'(rem) + ACC_W'(scaled);
        mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        whole = mag[ACC_W-1:FRAC_BITS];
        low   = {1'b0, mag[FRAC_BITS-1:0]};
        if (whole > WHOLE_W'(HID_MAX)) begin
            // clamp and drop the remainder
            res.move = acc[ACC_W-1] ? HID_MIN : HID_MAX;
            res.frac = '0;
        end else if (acc[ACC_W-1]) begin
            res.move = -whole[MOVE_W-1:0];
            res.frac = -$signed(low);
        end else begin
            res.move = whole[MOVE_W-1:0];
            res.frac = $signed(low);
        end
        return res;
    endfunction

    assign active  = i_is_enabled && i_is_touched;
    assign dx_full = $signed({1'b0, i_pos_x}) - $signed({1'b0, r_last_x});
    assign dy_full = $signed({1'b0, i_pos_y}) - $signed({1'b0, r_last_y});
    assign ax_full = dx_full[POS_W] ? POS_W'(-dx_full) : dx_full[POS_W-1:0];
    assign ay_full = dy_full[POS_W] ? POS_W'(-dy_full) : dy_full[POS_W-1:0];
    assign jump    = (ax_full > POS_W'(r_jump_limit)) || (ay_full > POS_W'(r_jump_limit));
    assign o_status.go = active && r_tracking && !jump;

    assign speed    = (r_ax > r_ay) ? r_ax : r_ay;
    assign over     = (speed > r_accel_thr) ? speed - r_accel_thr : '0;
    assign gain_sum = SUM_W'(r_gain_base) + SUM_W'(r_over_prod);

    assign res_x = take_whole(r_frac_x, r_scaled_x);
    assign res_y = take_whole(r_frac_y, r_scaled_y);

    assign o_move_x = r_move_x;
    assign o_move_y = r_move_y;

    // configuration and sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= RST_JUMP_LIMIT;
            r_accel_thr  <= RST_ACCEL_THR;
            r_gain_base  <= RST_GAIN_BASE;
            r_gain_slope <= RST_GAIN_SLOPE;
            r_gain_cap   <= RST_GAIN_CAP;
            r_tracking   <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_frac_x     <= '0;
            r_frac_y     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data[LIM_W-1:0];
                    CFG_ACCEL_THR:  r_accel_thr  <= i_cfg_data[LIM_W-1:0];
                    CFG_GAIN_BASE:  r_gain_base  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_SLOPE: r_gain_slope <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_CAP:   r_gain_cap   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (!active) begin
                    r_tracking <= 1'b0;
                    r_last_x   <= '0;
                    r_last_y   <= '0;
                    r_frac_x   <= '0;
                    r_frac_y   <= '0;
                end else begin
                    r_tracking <= 1'b1;
                    r_last_x   <= i_pos_x;
                    r_last_y   <= i_pos_y;
                    if (r_tracking && jump) begin
                        r_frac_x <= '0;
                        r_frac_y <= '0;
                    end
                end
            end
            if (i_cmd.fin && !r_zero) begin
                r_frac_x <= res_x.frac;
                r_frac_y <= res_y.frac;
            end
        end
    end

    // gain and scaling pipeline, output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= !o_status.go;
            r_dx   <= dx_full[DX_W-1:0];
            r_dy   <= dy_full[DX_W-1:0];
            r_ax   <= ax_full[LIM_W-1:0];
            r_ay   <= ay_full[LIM_W-1:0];
        end
        if (i_cmd.gain) begin
            r_over_prod <= OVER_P_W'(over * r_gain_slope);
        end
        if (i_cmd.cap) begin
            r_gain <= (gain_sum > SUM_W'(r_gain_cap)) ? r_gain_cap : gain_sum[GAIN_W-1:0];
        end
        if (i_cmd.mul) begin
            r_scaled_x <= PROD_W'(r_dx * $signed({1'b0, r_gain}));
            r_scaled_y <= PROD_W'(r_dy * $signed({1'b0, r_gain}));
        end
        if (i_cmd.fin) begin
            r_move_x <= r_zero ? '0 : res_x.move;
            r_move_y <= r_zero ? '0 : res_y.move;
        end
    end

    a_no_neg128_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_move_x != 8'h80))
        else $error("x motion left the HID range");

    a_no_neg128_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_move_y != 8'h80))
        else $error("y motion left the HID range");

    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !active) |=> (!r_tracking && r_frac_x == '0 && r_frac_y == '0))
        else $error("release did not clear tracking state");

endmodule

`default_nettype wire
